@@ hdl/assert_macros.svh @@
// Assertion macros used by the sRGB encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define SRGBE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srgbe assertion failed");

// Check the consequent in the cycle after the antecedent.
`define SRGBE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srgbe assertion failed");

`endif

@@ hdl/srgbe_pkg.sv @@
// Types, constants and helper functions for the sRGB encoder.
`default_nettype none

package srgbe_pkg;

   localparam int unsigned FP_W    = 32;
   localparam int unsigned Q_FRAC  = 24;
   localparam int unsigned Q_W     = Q_FRAC + 1;
   localparam int unsigned CODE_W  = 8;

   localparam logic [Q_W-1:0]    ONE_Q24    = Q_W'(1) << Q_FRAC;
   localparam logic [Q_W-1:0]    THRESH_Q24 = Q_W'(52526);
   localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(255);

   localparam int unsigned    LIN_STEPS  = 10;
   localparam int unsigned    LIN_CODE_W = 4;
   localparam longint unsigned LIN_MUL   = 64'd32946;
   localparam longint unsigned LIN_HALF  = 64'd83886080;

   localparam int unsigned SQRT_IN_W   = 2 * Q_FRAC + 1;
   localparam int unsigned SQRT_ACC_W  = SQRT_IN_W + 1;
   localparam int unsigned SQRT_OUT_W  = Q_W;
   localparam int unsigned SQRT_STAGES = Q_FRAC + 1;

   localparam int unsigned CBRT_IN_W   = 2 * Q_FRAC + 1;
   localparam int unsigned CBRT_OUT_W  = 17;
   localparam int unsigned CBRT_STAGES = CBRT_OUT_W;
   localparam int unsigned CBRT_SQ_W   = 35;
   localparam int unsigned CBRT_CMP_W  = 52;

   localparam int unsigned     NUM_W       = 36;
   localparam logic [NUM_W-1:0] POW_GAIN   = NUM_W'(269122);
   localparam logic [NUM_W-1:0] POW_OFFSET = NUM_W'(888012800);
   localparam int unsigned     V_LSB       = 16;
   localparam int unsigned     V_W         = 18;
   localparam int unsigned     RECIP_W     = 19;
   localparam int unsigned     M_W         = V_W + RECIP_W;
   localparam logic [M_W-1:0]  RECIP_1000  = M_W'(268436);
   localparam int unsigned     RECIP_SHIFT = 28;

   localparam int unsigned       ALPHA_W    = Q_W + CODE_W;
   localparam logic [ALPHA_W-1:0] ALPHA_HALF = ALPHA_W'(1) << (Q_FRAC - 1);

   localparam int unsigned LANE_XDLY     = 2 * SQRT_STAGES;
   localparam int unsigned LANE_DEPTH    = 2 * SQRT_STAGES + CBRT_STAGES + 6;
   localparam int unsigned LANE_SIDE_LEN = LANE_DEPTH - 2;

   typedef struct packed {
      logic                  low;
      logic [LIN_CODE_W-1:0] lin_code;
   } srgbe_side_type;

   typedef struct packed {
      logic [CODE_W-1:0] red;
      logic [CODE_W-1:0] green;
      logic [CODE_W-1:0] blue;
      logic [CODE_W-1:0] alpha;
   } srgbe_pixel_type;

   function automatic logic [Q_W-1:0] clamp_q24(input logic [FP_W-1:0] f);
      logic       sign;
      logic [7:0] ex;
      logic [22:0] man;
      logic [7:0] sh;
      logic [Q_W-1:0] x;
      sign = f[31];
      ex   = f[30:23];
      man  = f[22:0];
      sh   = 8'd126 - ex;
      if (ex == 8'hFF && man != '0) begin
         x = '0;
      end else if (sign) begin
         x = '0;
      end else if (ex >= 8'd127) begin
         x = ONE_Q24;
      end else if (ex == 8'd0) begin
         x = '0;
      end else if (sh > 8'd23) begin
         x = '0;
      end else begin
         x = {1'b0, {1'b1, man} >> sh[4:0]};
      end
      return x;
   endfunction

   function automatic logic [Q_W-1:0] lin_step_x(input int unsigned k);
      return Q_W'((64'(2 * k - 1) * LIN_HALF + LIN_MUL - 64'd1) / LIN_MUL);
   endfunction

endpackage

`default_nettype wire

@@ hdl/srgbe_ifs.sv @@
// Request and response channel interfaces of the sRGB encoder.
`default_nettype none

interface srgbe_req_if;
   logic                          valid;
   logic                          ready;
   logic [srgbe_pkg::FP_W-1:0]    red_linear;
   logic [srgbe_pkg::FP_W-1:0]    green_linear;
   logic [srgbe_pkg::FP_W-1:0]    blue_linear;
   logic [srgbe_pkg::FP_W-1:0]    alpha_linear;

   modport source (output valid, output red_linear, output green_linear,
                   output blue_linear, output alpha_linear, input ready);
   modport sink   (input valid, input red_linear, input green_linear,
                   input blue_linear, input alpha_linear, output ready);
endinterface

interface srgbe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srgbe_pkg::CODE_W-1:0]  red_code;
   logic [srgbe_pkg::CODE_W-1:0]  green_code;
   logic [srgbe_pkg::CODE_W-1:0]  blue_code;
   logic [srgbe_pkg::CODE_W-1:0]  alpha_code;

   modport source (output valid, output red_code, output green_code,
                   output blue_code, output alpha_code, input ready);
   modport sink   (input valid, input red_code, input green_code,
                   input blue_code, input alpha_code, output ready);
endinterface

`default_nettype wire

@@ hdl/srgb_encode_rgba_to_bytes.sv @@
// Top level of the sRGB encoder: three colour lanes, an alpha lane and the merge stage.
// Throughput: one pixel per clock; a new transaction is taken every cycle unless the skid is full.
// The path from acceptance to rsp_bus.valid is set by the two 25-stage square roots
// and the 17-stage cube root in each colour lane.
// Reset: synchronous, active high; clears the stage valid bits and the output and skid flags.
`default_nettype none

module srgb_encode_rgba_to_bytes (
   input  wire logic   clock,
   input  wire logic   reset,
   srgbe_req_if.sink   req_bus,
   srgbe_rsp_if.source rsp_bus
);

   localparam int unsigned DEPTH   = srgbe_pkg::LANE_DEPTH;
   localparam int unsigned Q_W     = srgbe_pkg::Q_W;
   localparam int unsigned Q_FRAC  = srgbe_pkg::Q_FRAC;
   localparam int unsigned CODE_W  = srgbe_pkg::CODE_W;
   localparam int unsigned ALPHA_W = srgbe_pkg::ALPHA_W;
   localparam int unsigned RAW_W   = ALPHA_W - Q_FRAC;

   logic                       adv;
   logic                       skid_full;
   logic [DEPTH-1:0]           vld_ff;
   logic [Q_W-1:0]             ax_ff;
   logic [ALPHA_W-1:0]         a_sum;
   logic [RAW_W-1:0]           a_raw;
   logic [CODE_W-1:0]          a_code;
   logic [CODE_W-1:0]          adly_ff [DEPTH-1];
   srgbe_pkg::srgbe_pixel_type pixel;

   assign adv           = !skid_full;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_bus.valid};
      end
   end

   srgbe_colour_lane u_lane_red (
      .clock     (clock),
      .en        (adv),
      .linear_in (req_bus.red_linear),
      .code_out  (pixel.red)
   );

   srgbe_colour_lane u_lane_green (
      .clock     (clock),
      .en        (adv),
      .linear_in (req_bus.green_linear),
      .code_out  (pixel.green)
   );

   srgbe_colour_lane u_lane_blue (
      .clock     (clock),
      .en        (adv),
      .linear_in (req_bus.blue_linear),
      .code_out  (pixel.blue)
   );

   // a * 255 + 0.5, then drop the fraction
   assign a_sum  = (ALPHA_W'(ax_ff) << CODE_W) - ALPHA_W'(ax_ff) + srgbe_pkg::ALPHA_HALF;
   assign a_raw  = a_sum[ALPHA_W-1:Q_FRAC];
   assign a_code = (a_raw > RAW_W'(srgbe_pkg::CODE_MAX)) ? srgbe_pkg::CODE_MAX
                                                         : a_raw[CODE_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff      <= srgbe_pkg::clamp_q24(req_bus.alpha_linear);
         adly_ff[0] <= a_code;
         for (int k = 1; k < DEPTH - 1; k++) begin
            adly_ff[k] <= adly_ff[k-1];
         end
      end
   end

   assign pixel.alpha = adly_ff[DEPTH-2];

   srgbe_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (adv && vld_ff[DEPTH-1]),
      .pixel_in  (pixel),
      .skid_full (skid_full),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

@@ hdl/srgbe_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module srgbe_isqrt (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [srgbe_pkg::SQRT_IN_W-1:0]   n_in,
   output logic      [srgbe_pkg::SQRT_OUT_W-1:0]  root_out
);

   localparam int unsigned IN_W   = srgbe_pkg::SQRT_IN_W;
   localparam int unsigned ACC_W  = srgbe_pkg::SQRT_ACC_W;
   localparam int unsigned OUT_W  = srgbe_pkg::SQRT_OUT_W;
   localparam int unsigned STAGES = srgbe_pkg::SQRT_STAGES;

   logic [IN_W-1:0]  rem_ff [STAGES-1];
   logic [ACC_W-1:0] acc_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (STAGES - 1 - k));
      logic [IN_W-1:0]  rem_p;
      logic [ACC_W-1:0] acc_p;
      logic [ACC_W-1:0] trial;
      logic             fits;

      if (k == 0) begin : g_first
         assign rem_p = n_in;
         assign acc_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign acc_p = acc_ff[k-1];
      end

      assign trial = acc_p + BIT;
      assign fits  = ACC_W'(rem_p) >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= fits ? (acc_p >> 1) + BIT : acc_p >> 1;
         end
      end

      if (k < STAGES - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= fits ? rem_p - IN_W'(trial) : rem_p;
            end
         end
      end
   end

   assign root_out = acc_ff[STAGES-1][OUT_W-1:0];

endmodule

`default_nettype wire

@@ hdl/srgbe_icbrt.sv @@
// Pipelined integer cube root, one result bit per stage, shift-and-add only.
`default_nettype none

module srgbe_icbrt (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [srgbe_pkg::CBRT_IN_W-1:0]   n_in,
   output logic      [srgbe_pkg::CBRT_OUT_W-1:0]  root_out
);

   localparam int unsigned IN_W   = srgbe_pkg::CBRT_IN_W;
   localparam int unsigned OUT_W  = srgbe_pkg::CBRT_OUT_W;
   localparam int unsigned SQ_W   = srgbe_pkg::CBRT_SQ_W;
   localparam int unsigned CMP_W  = srgbe_pkg::CBRT_CMP_W;
   localparam int unsigned STAGES = srgbe_pkg::CBRT_STAGES;

   logic [IN_W-1:0]  rem_ff [STAGES-1];
   logic [SQ_W-1:0]  sq_ff  [STAGES-1];
   logic [OUT_W-1:0] root_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int unsigned B = STAGES - 1 - k;
      logic [IN_W-1:0]  rem_p;
      logic [SQ_W-1:0]  sq_p;
      logic [OUT_W-1:0] root_p;
      logic [CMP_W-1:0] sq_w;
      logic [CMP_W-1:0] root_w;
      logic [CMP_W-1:0] delta;
      logic             fits;

      if (k == 0) begin : g_first
         assign rem_p  = n_in;
         assign sq_p   = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign sq_p   = sq_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      // (r + 2^b)^3 - r^3 = 3 r^2 2^b + 3 r 2^2b + 2^3b
      assign sq_w   = CMP_W'(sq_p);
      assign root_w = CMP_W'(root_p);
      assign delta  = (sq_w << B) + (sq_w << (B + 1)) + (root_w << (2 * B))
                    + (root_w << (2 * B + 1)) + (CMP_W'(1) << (3 * B));
      assign fits   = CMP_W'(rem_p) >= delta;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= fits ? root_p | (OUT_W'(1) << B) : root_p;
         end
      end

      if (k < STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               if (fits) begin
                  rem_ff[k] <= rem_p - IN_W'(delta);
                  sq_ff[k]  <= sq_p + (SQ_W'(root_p) << (B + 1)) + (SQ_W'(1) << (2 * B));
               end else begin
                  rem_ff[k] <= rem_p;
                  sq_ff[k]  <= sq_p;
               end
            end
         end
      end
   end

   assign root_out = root_ff[STAGES-1];

endmodule

`default_nettype wire

@@ hdl/srgbe_colour_lane.sv @@
// One colour lane: clamp to Q1.24, then linear segment or power curve to a byte.
`default_nettype none

module srgbe_colour_lane (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [srgbe_pkg::FP_W-1:0]    linear_in,
   output logic      [srgbe_pkg::CODE_W-1:0]  code_out
);

   localparam int unsigned Q_W      = srgbe_pkg::Q_W;
   localparam int unsigned Q_FRAC   = srgbe_pkg::Q_FRAC;
   localparam int unsigned CODE_W   = srgbe_pkg::CODE_W;
   localparam int unsigned STEPS    = srgbe_pkg::LIN_STEPS;
   localparam int unsigned LC_W     = srgbe_pkg::LIN_CODE_W;
   localparam int unsigned XDLY     = srgbe_pkg::LANE_XDLY;
   localparam int unsigned SIDE_LEN = srgbe_pkg::LANE_SIDE_LEN;
   localparam int unsigned PROD_W   = 2 * Q_W;
   localparam int unsigned NUM_W    = srgbe_pkg::NUM_W;
   localparam int unsigned V_W      = srgbe_pkg::V_W;
   localparam int unsigned V_LSB    = srgbe_pkg::V_LSB;
   localparam int unsigned M_W      = srgbe_pkg::M_W;
   localparam int unsigned SHIFT    = srgbe_pkg::RECIP_SHIFT;
   localparam int unsigned RAW_W    = M_W - SHIFT;

   logic [Q_W-1:0]                   x_ff;
   logic [Q_W-1:0]                   xd_ff [XDLY];
   srgbe_pkg::srgbe_side_type        side_in;
   srgbe_pkg::srgbe_side_type        side_ff [SIDE_LEN];
   logic [STEPS-1:0]                 hit;
   logic [srgbe_pkg::SQRT_OUT_W-1:0] sroot;
   logic [srgbe_pkg::SQRT_OUT_W-1:0] qroot;
   logic [PROD_W-1:0]                prod;
   logic [Q_W-1:0]                   p_ff;
   logic [srgbe_pkg::CBRT_OUT_W-1:0] croot;
   logic [NUM_W-1:0]                 num_ff;
   logic [NUM_W-1:0]                 diff;
   logic [V_W-1:0]                   v_ff;
   logic [M_W-1:0]                   m_ff;
   logic [RAW_W-1:0]                 pow_raw;
   logic [CODE_W-1:0]                pow_code;
   logic [CODE_W-1:0]                code_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= srgbe_pkg::clamp_q24(linear_in);
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_lin
      localparam logic [Q_W-1:0] STEP_X = srgbe_pkg::lin_step_x(k + 1);
      assign hit[k] = x_ff >= STEP_X;
   end

   always_comb begin
      logic [LC_W-1:0] cnt;
      cnt = '0;
      for (int k = 0; k < STEPS; k++) begin
         cnt = cnt + LC_W'(hit[k]);
      end
      side_in.low      = x_ff < srgbe_pkg::THRESH_Q24;
      side_in.lin_code = cnt;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         xd_ff[0]   <= x_ff;
         for (int k = 1; k < SIDE_LEN; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 1; k < XDLY; k++) begin
            xd_ff[k] <= xd_ff[k-1];
         end
      end
   end

   srgbe_isqrt u_sqrt_half (
      .clock    (clock),
      .en       (en),
      .n_in     ({x_ff, {Q_FRAC{1'b0}}}),
      .root_out (sroot)
   );

   srgbe_isqrt u_sqrt_quarter (
      .clock    (clock),
      .en       (en),
      .n_in     ({sroot, {Q_FRAC{1'b0}}}),
      .root_out (qroot)
   );

   assign prod = PROD_W'(xd_ff[XDLY-1]) * PROD_W'(qroot);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= prod[Q_FRAC+Q_W-1:Q_FRAC];
      end
   end

   srgbe_icbrt u_cbrt (
      .clock    (clock),
      .en       (en),
      .n_in     ({p_ff, {Q_FRAC{1'b0}}}),
      .root_out (croot)
   );

   assign diff     = num_ff - srgbe_pkg::POW_OFFSET;
   assign pow_raw  = m_ff[M_W-1:SHIFT];
   assign pow_code = (pow_raw > RAW_W'(srgbe_pkg::CODE_MAX)) ? srgbe_pkg::CODE_MAX
                                                             : pow_raw[CODE_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= NUM_W'(croot) * srgbe_pkg::POW_GAIN;
         v_ff    <= (num_ff < srgbe_pkg::POW_OFFSET) ? '0 : diff[V_LSB+V_W-1:V_LSB];
         m_ff    <= M_W'(v_ff) * srgbe_pkg::RECIP_1000;
         code_ff <= side_ff[SIDE_LEN-1].low ? CODE_W'(side_ff[SIDE_LEN-1].lin_code)
                                            : pow_code;
      end
   end

   assign code_out = code_ff;

endmodule

`default_nettype wire

@@ hdl/srgbe_merge.sv @@
// Merge stage: packs the lane codes into one transaction, output register plus skid.
`default_nettype none

`include "assert_macros.svh"

module srgbe_merge (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire srgbe_pkg::srgbe_pixel_type pixel_in,
   output logic                            skid_full,
   srgbe_rsp_if.source                     rsp_bus
);

   srgbe_pkg::srgbe_pixel_type out_ff;
   srgbe_pkg::srgbe_pixel_type skid_ff;
   logic                       out_vld_ff;
   logic                       out_vld_in;
   logic                       skid_vld_ff;
   logic                       skid_vld_in;
   logic                       take;

   assign take = out_vld_ff && rsp_bus.ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (!out_vld_ff || take) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = push;
         end
      end else if (push) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || take) begin
         out_ff <= skid_vld_ff ? skid_ff : pixel_in;
      end else if (push) begin
         skid_ff <= pixel_in;
      end
   end

   assign skid_full          = skid_vld_ff;
   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.red_code   = out_ff.red;
   assign rsp_bus.green_code = out_ff.green;
   assign rsp_bus.blue_code  = out_ff.blue;
   assign rsp_bus.alpha_code = out_ff.alpha;

   `SRGBE_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_vld_ff, out_vld_ff)
   `SRGBE_ASSERT_NOW(a_no_push_into_full, clock, reset, push, !skid_vld_ff)
   `SRGBE_ASSERT_NEXT(a_skid_drains, clock, reset, skid_vld_ff && take, out_vld_ff && !skid_vld_ff)

endmodule

`default_nettype wire
